>>> hdl/dtq_pkg.sv
// Package: opcodes, result kinds and channel payload layout for the timer queue.
package dtq_pkg;

  localparam logic [1:0] OP_SUBMIT   = 2'd0;
  localparam logic [1:0] OP_CANCEL   = 2'd1;
  localparam logic [1:0] OP_TICK     = 2'd2;
  localparam logic [1:0] OP_SHUTDOWN = 2'd3;

  localparam logic [2:0] K_ACCEPTED    = 3'd0;
  localparam logic [2:0] K_EXPIRED     = 3'd1;
  localparam logic [2:0] K_ABORTED     = 3'd2;
  localparam logic [2:0] K_FULL        = 3'd3;
  localparam logic [2:0] K_CANCELED    = 3'd4;
  localparam logic [2:0] K_NOT_FOUND   = 3'd5;
  localparam logic [2:0] K_NOTHING_DUE = 3'd6;
  localparam logic [2:0] K_IGNORED     = 3'd7;

  localparam int TIME_BITS = 32;
  localparam int TAG_BITS  = 16;

  localparam int IN_TDATA_BITS  = ((2 + TIME_BITS + TAG_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_BITS = ((3 + TAG_BITS + 7) / 8) * 8;

  typedef struct packed {
    logic                last;
    logic [2:0]          kind;
    logic [TAG_BITS-1:0] handle;
  } result_t;

endpackage

>>> hdl/dtq_mem.sv
// Slot memory: deadline and tag per slot, one write and one registered read port.
module dtq_mem #(
  parameter int SLOTS     = 16,
  parameter int TIME_BITS = 32,
  parameter int TAG_BITS  = 16,
  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AW-1:0]        waddr_i,
  input  logic [TIME_BITS-1:0] wdl_i,
  input  logic [TAG_BITS-1:0]  wtag_i,
  input  logic [AW-1:0]        raddr_i,
  output logic [TIME_BITS-1:0] rdl_o,
  output logic [TAG_BITS-1:0]  rtag_o
);
  logic [TIME_BITS-1:0] dl_mem  [SLOTS];
  logic [TAG_BITS-1:0]  tag_mem [SLOTS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      dl_mem[waddr_i]  <= wdl_i;
      tag_mem[waddr_i] <= wtag_i;
    end
    rdl_o  <= dl_mem[raddr_i];
    rtag_o <= tag_mem[raddr_i];
  end
endmodule

>>> hdl/deadline_timer_queue_top.sv
// Top level: deadline-ordered timer queue with cancel, tick firing and shutdown.
//
// channel  dir  tdata (low bit up)                         tuser / tlast
// s_axis   in   opcode[1:0] time_value[33:2] handle[49:34]  -
// m_axis   out  result_kind[2:0] result_handle[18:3]       tlast = last_of_run
//
// Submit and shutdown-state items are answered from idle without a scan. Cancel scans all
// slots through the single memory read port. A tick or shutdown runs one full scan per
// fired entry plus one final scan that finds none.
// Reset clears valid bits, tag counter and shutdown flag; the memory needs no clearing.
// A stalled output holds the run at its emit step; the next request is taken once the last result issues.
module deadline_timer_queue_top #(
  parameter int SLOTS     = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [dtq_pkg::IN_TDATA_BITS-1:0]   s_axis_tdata,  // opcode, time_value, target_handle
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [dtq_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata,  // result_kind, result_handle
  output logic                                m_axis_tlast
);
  import dtq_pkg::*;

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_EMIT = 3'd2;
  localparam logic [2:0] ST_OUT  = 3'd3;

  logic [2:0]           st_q, st_d;
  logic [SLOTS-1:0]     valid_q, valid_d;
  logic [TAG_BITS-1:0]  ntag_q, ntag_d;
  logic                 shut_q, shut_d;
  logic [1:0]           op_q, op_d;
  logic [TIME_BITS-1:0] t_q, t_d;
  logic [TAG_BITS-1:0]  tgt_q, tgt_d;
  logic                 bounded_q, bounded_d;
  logic [2:0]           kind_q, kind_d;
  logic                 any_q, any_d;
  logic [CW-1:0]        ra_q, ra_d;
  logic                 rv_q, rv_d;
  logic [AW-1:0]        rs_q, rs_d;
  logic                 bh_q, bh_d;
  logic [AW-1:0]        bs_q, bs_d;
  logic [TIME_BITS-1:0] bdl_q, bdl_d;
  logic [TAG_BITS-1:0]  btag_q, btag_d;
  logic                 ov_q, ov_d;
  result_t              o_q, o_d;

  logic                 we;
  logic [AW-1:0]        waddr;
  logic [TIME_BITS-1:0] rdl;
  logic [TAG_BITS-1:0]  rtag;
  logic                 free_found;
  logic [AW-1:0]        free_idx;
  logic                 in_fire, out_free;
  logic [1:0]           in_op;
  logic [TIME_BITS-1:0] in_t;
  logic [TAG_BITS-1:0]  in_tag;

  assign in_op  = s_axis_tdata[1:0];
  assign in_t   = s_axis_tdata[2 +: TIME_BITS];
  assign in_tag = s_axis_tdata[2 + TIME_BITS +: TAG_BITS];
  assign s_axis_tready = (st_q == ST_IDLE) && !ov_q;
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign out_free = !ov_q || m_axis_tready;

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {{(OUT_TDATA_BITS-3-TAG_BITS){1'b0}}, o_q.handle, o_q.kind};
  assign m_axis_tlast  = o_q.last;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = AW'(i);
      end
    end
  end

  dtq_mem #(.SLOTS(SLOTS), .TIME_BITS(TIME_BITS), .TAG_BITS(TAG_BITS)) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdl_i   (in_t),
    .wtag_i  (ntag_q),
    .raddr_i (ra_q[AW-1:0]),
    .rdl_o   (rdl),
    .rtag_o  (rtag)
  );

  always_comb begin
    st_d = st_q; valid_d = valid_q; ntag_d = ntag_q; shut_d = shut_q;
    op_d = op_q; t_d = t_q; tgt_d = tgt_q; bounded_d = bounded_q; kind_d = kind_q;
    any_d = any_q; ra_d = ra_q; rv_d = 1'b0; rs_d = rs_q; bh_d = bh_q; bs_d = bs_q;
    bdl_d = bdl_q; btag_d = btag_q; ov_d = ov_q; o_d = o_q;
    we = 1'b0; waddr = free_idx;
    if (ov_q && m_axis_tready) ov_d = 1'b0;
    case (st_q)
      ST_IDLE: begin
        if (in_fire) begin
          op_d = in_op; t_d = in_t; tgt_d = in_tag;
          ra_d = '0; bh_d = 1'b0; any_d = 1'b0;
          o_d.last = 1'b1; o_d.handle = '0;
          if (in_op == OP_SUBMIT) begin
            ov_d = 1'b1;
            if (shut_q) begin
              o_d.kind = K_ABORTED; o_d.handle = ntag_q; ntag_d = ntag_q + 1'b1;
            end else if (!free_found) begin
              o_d.kind = K_FULL;
            end else begin
              we = 1'b1; valid_d[free_idx] = 1'b1;
              o_d.kind = K_ACCEPTED; o_d.handle = ntag_q; ntag_d = ntag_q + 1'b1;
            end
          end else if (shut_q) begin
            ov_d = 1'b1; o_d.kind = K_IGNORED;
          end else begin
            bounded_d = (in_op == OP_TICK);
            kind_d = (in_op == OP_TICK) ? K_EXPIRED : K_ABORTED;
            if (in_op == OP_SHUTDOWN) shut_d = 1'b1;
            st_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (ra_q < CW'(SLOTS)) begin
          rv_d = 1'b1; rs_d = ra_q[AW-1:0]; ra_d = ra_q + 1'b1;
        end
        if (rv_q && valid_q[rs_q]) begin
          if (op_q == OP_CANCEL) begin
            if (!bh_q && rtag == tgt_q) begin
              bh_d = 1'b1; bs_d = rs_q; btag_d = rtag;
            end
          end else if ((!bounded_q || rdl <= t_q) && (!bh_q || rdl < bdl_q)) begin
            bh_d = 1'b1; bs_d = rs_q; bdl_d = rdl; btag_d = rtag;
          end
        end
        if (!rv_q && ra_q == CW'(SLOTS)) st_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          ra_d = '0; bh_d = 1'b0;
          if (op_q == OP_CANCEL) begin
            ov_d = 1'b1; o_d.last = 1'b1;
            if (bh_q) begin
              valid_d[bs_q] = 1'b0; o_d.kind = K_CANCELED; o_d.handle = btag_q;
            end else begin
              o_d.kind = K_NOT_FOUND; o_d.handle = '0;
            end
            st_d = ST_IDLE;
          end else if (bh_q) begin
            if (any_q) begin
              ov_d = 1'b1; o_d.last = 1'b0; o_d.kind = kind_q;
              o_d.handle = tgt_q;
            end
            // hold current hit; emit it next round once we know if another follows
            valid_d[bs_q] = 1'b0; any_d = 1'b1;
            btag_d = btag_q;
            st_d = ST_OUT;
          end else begin
            ov_d = 1'b1; o_d.last = 1'b1;
            if (any_q) begin
              o_d.kind = kind_q; o_d.handle = tgt_q;
            end else begin
              o_d.kind = K_NOTHING_DUE; o_d.handle = '0;
            end
            st_d = ST_IDLE;
          end
        end
      end
      ST_OUT: begin
        tgt_d = btag_q;
        st_d = ST_SCAN;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; valid_q <= '0; ntag_q <= '0; shut_q <= 1'b0;
      ov_q <= 1'b0; rv_q <= 1'b0; bh_q <= 1'b0; any_q <= 1'b0;
    end else begin
      st_q <= st_d; valid_q <= valid_d; ntag_q <= ntag_d; shut_q <= shut_d;
      ov_q <= ov_d; rv_q <= rv_d; bh_q <= bh_d; any_q <= any_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; t_q <= t_d; tgt_q <= tgt_d; bounded_q <= bounded_d; kind_q <= kind_d;
    ra_q <= ra_d; rs_q <= rs_d; bs_q <= bs_d; bdl_q <= bdl_d; btag_q <= btag_d; o_q <= o_d;
  end

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> st_q == ST_IDLE) else $error("ready outside idle");
  a_shut_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(shut_q) |-> shut_q) else $error("shutdown flag cleared");
  a_full_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_d && !ov_q && o_d.kind == K_FULL) |=> $stable(ntag_q))
    else $error("full took a tag");

endmodule
